// ===== src/string_to_signed_integer_parser_assert.svh =====
// ---------------------------------------------------------------------------
// string_to_signed_integer_parser_assert.svh
// assertion macros shared by the parser's checker
// ---------------------------------------------------------------------------
`ifndef STRING_TO_SIGNED_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_SIGNED_INTEGER_PARSER_ASSERT_SVH

// consequent must hold in the same cycle
`define STOI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stoi: same-cycle check failed");

// consequent must hold in the next cycle
`define STOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stoi: next-cycle check failed");

`endif

// ===== src/stoi_pkg.sv =====
// ---------------------------------------------------------------------------
// stoi_pkg
// shared widths, codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package stoi_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int OUT_WIDTH    = 64;
   localparam int CHAR_WIDTH   = 8;
   localparam int RADIX_WIDTH  = 6;
   localparam int STATUS_WIDTH = 2;
   localparam int BOP_WIDTH    = 3;

   localparam logic [CHAR_WIDTH-1:0] NUL_CHAR = 8'h00;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE   = 2'd2;

   // base register operations
   localparam logic [BOP_WIDTH-1:0] BOP_NONE    = 3'd0;
   localparam logic [BOP_WIDTH-1:0] BOP_RADIX   = 3'd1;
   localparam logic [BOP_WIDTH-1:0] BOP_EIGHT   = 3'd2;
   localparam logic [BOP_WIDTH-1:0] BOP_TEN     = 3'd3;
   localparam logic [BOP_WIDTH-1:0] BOP_SIXTEEN = 3'd4;

   // saturated results, sign extended to the output width
   localparam logic [OUT_WIDTH-1:0] SAT_MAX_EXT =
      {{(OUT_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] SAT_MIN_EXT = ~SAT_MAX_EXT;

   typedef struct packed {
      logic [BOP_WIDTH-1:0] base_op;
      logic                 set_sign;
      logic                 set_invalid;
      logic                 start_mul;
      logic                 commit;
      logic                 emit;
      logic                 clear;
   } stoi_cmd_type;

   typedef struct packed {
      logic is_nul;
      logic is_blank;
      logic is_sign;
      logic is_char0;
      logic is_x;
      logic base_bad;
      logic radix_auto;
      logic held_auto;
      logic digit_lt_radix;
      logic digit_lt_ten;
      logic digit_lt_held;
      logic overflow;
   } stoi_status_type;

endpackage

// ===== src/string_to_signed_integer_parser.sv =====
// ---------------------------------------------------------------------------
// string_to_signed_integer_parser
// strtoimax-style parser: text bytes in, one signed value and status out
// ---------------------------------------------------------------------------
// a string arrives one byte per req beat and ends with a zero byte; the zero
// byte produces exactly one rsp beat (value and status), registered into the
// next cycle; every other byte produces none. leading white space is skipped,
// then an optional sign, then in automatic mode (radix 0) a "0" prefix picks
// octal, "0x"/"0X" hex and anything else decimal. radix is sampled while
// leading white space is skipped and held for the rest of the string. status
// 0 is ok, 1 a bad radix or trailing garbage, 2 overflow (value saturated).
// for a digit byte the accumulator-by-base multiply is registered and the add
// of the digit and the range compare run in the following cycle, with
// req_stall high while they run; all other bytes are taken without a stall.
// bytes are taken while a result waits on rsp; only a zero byte is held back
// until the waiting result beat goes out.
// ---------------------------------------------------------------------------
module string_to_signed_integer_parser
   import stoi_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request channel, one text byte per beat
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [CHAR_WIDTH-1:0]       req_char_code,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_value,
   output logic [STATUS_WIDTH-1:0]     rsp_status,
   // radix register (0 = automatic)
   input  logic                        csr_wr_en,
   input  logic [RADIX_WIDTH-1:0]      csr_wr_data
);

   stoi_cmd_type    cmd;
   stoi_status_type st;

   // phase tracking, handshakes and command sequencing
   stoi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // byte decode, accumulator, multiplier and result registers
   stoi_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .st            (st),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== src/stoi_dpath.sv =====
// ---------------------------------------------------------------------------
// stoi_dpath
// character decode, radix register, accumulator, multiply and range check
// ---------------------------------------------------------------------------
module stoi_dpath
   import stoi_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic [CHAR_WIDTH-1:0]          req_char_code,
   input  logic                           csr_wr_en,
   input  logic [RADIX_WIDTH-1:0]         csr_wr_data,
   input  stoi_cmd_type                   cmd,
   output stoi_status_type                st,
   output logic signed [OUT_WIDTH-1:0]    rsp_value,
   output logic [STATUS_WIDTH-1:0]        rsp_status
);

   localparam int PROD_WIDTH = VALUE_WIDTH + RADIX_WIDTH;

   localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET  = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] BASE_ONE     = 6'd1;
   localparam logic [RADIX_WIDTH-1:0] BASE_EIGHT   = 6'd8;
   localparam logic [RADIX_WIDTH-1:0] BASE_TEN     = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] BASE_SIXTEEN = 6'd16;
   localparam logic [RADIX_WIDTH-1:0] BASE_MAX     = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] DIGIT_NONE   = 6'd36;
   localparam logic [CHAR_WIDTH-1:0]  LETTER_BIAS  = 8'd10;

   localparam logic [VALUE_WIDTH-1:0] MAG_POS_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] MAG_NEG_MAX = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   function automatic logic char_is_blank(input logic [CHAR_WIDTH-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [RADIX_WIDTH-1:0] d;
      d = DIGIT_NONE;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d = RADIX_WIDTH'(c - CH_ZERO);
      end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) begin
         d = RADIX_WIDTH'(c - CH_LOWER_A + LETTER_BIAS);
      end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
         d = RADIX_WIDTH'(c - CH_UPPER_A + LETTER_BIAS);
      end
      return d;
   endfunction

   logic [RADIX_WIDTH-1:0]  radix_ff,  radix_in;
   logic [VALUE_WIDTH-1:0]  acc_ff,    acc_in;
   logic                    neg_ff,    neg_in;
   logic [RADIX_WIDTH-1:0]  base_ff,   base_in;
   logic [STATUS_WIDTH-1:0] pend_ff,   pend_in;
   logic [PROD_WIDTH-1:0]   prod_ff,   prod_in;
   logic [RADIX_WIDTH-1:0]  digit_ff,  digit_in;
   logic [OUT_WIDTH-1:0]    value_ff,  value_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   logic [RADIX_WIDTH-1:0]  digit;
   logic [RADIX_WIDTH-1:0]  eff_base;
   logic [PROD_WIDTH-1:0]   sum;
   logic [VALUE_WIDTH-1:0]  limit;
   logic [VALUE_WIDTH-1:0]  signed_mag;

   // decode
   assign digit = digit_of(req_char_code);

   always_comb begin
      unique case (cmd.base_op)
         BOP_TEN:   eff_base = BASE_TEN;
         BOP_RADIX: eff_base = radix_ff;
         default:   eff_base = base_ff;
      endcase
   end

   assign sum   = prod_ff + PROD_WIDTH'(digit_ff);
   assign limit = neg_ff ? MAG_NEG_MAX : MAG_POS_MAX;

   always_comb begin
      st.is_nul         = (req_char_code == NUL_CHAR);
      st.is_blank       = char_is_blank(req_char_code);
      st.is_sign        = (req_char_code == CH_PLUS) || (req_char_code == CH_MINUS);
      st.is_char0       = (req_char_code == CH_ZERO);
      st.is_x           = (req_char_code == CH_LOWER_X) || (req_char_code == CH_UPPER_X);
      st.base_bad       = (radix_ff == BASE_ONE) || (radix_ff > BASE_MAX);
      st.radix_auto     = (radix_ff == '0);
      st.held_auto      = (base_ff == '0);
      st.digit_lt_radix = (digit < radix_ff);
      st.digit_lt_ten   = (digit < BASE_TEN);
      st.digit_lt_held  = (digit < base_ff);
      st.overflow       = (sum > PROD_WIDTH'(limit));
   end

   // next state
   always_comb begin
      radix_in  = csr_wr_en ? csr_wr_data : radix_ff;
      prod_in   = prod_ff;
      digit_in  = digit_ff;
      value_in  = value_ff;
      status_in = status_ff;
      signed_mag = neg_ff ? (VALUE_WIDTH'(0) - acc_ff) : acc_ff;

      if (cmd.start_mul) begin
         prod_in  = PROD_WIDTH'(acc_ff) * PROD_WIDTH'(eff_base);
         digit_in = digit;
      end

      if (cmd.emit) begin
         value_in  = OUT_WIDTH'($signed(signed_mag));
         status_in = cmd.set_invalid ? STATUS_INVALID : pend_ff;
      end

      priority if (cmd.clear) begin
         acc_in = '0;
      end else if (cmd.commit) begin
         acc_in = st.overflow ? limit : sum[VALUE_WIDTH-1:0];
      end else begin
         acc_in = acc_ff;
      end

      priority if (cmd.clear) begin
         neg_in = 1'b0;
      end else if (cmd.set_sign) begin
         neg_in = (req_char_code == CH_MINUS);
      end else begin
         neg_in = neg_ff;
      end

      priority if (cmd.clear) begin
         pend_in = STATUS_OK;
      end else if (cmd.set_invalid) begin
         pend_in = STATUS_INVALID;
      end else if (cmd.commit && st.overflow) begin
         pend_in = STATUS_RANGE;
      end else begin
         pend_in = pend_ff;
      end

      if (cmd.clear) begin
         base_in = '0;
      end else begin
         unique case (cmd.base_op)
            BOP_RADIX:   base_in = st.base_bad ? '0 : radix_ff;
            BOP_EIGHT:   base_in = BASE_EIGHT;
            BOP_TEN:     base_in = BASE_TEN;
            BOP_SIXTEEN: base_in = BASE_SIXTEEN;
            default:     base_in = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         pend_ff  <= STATUS_OK;
      end else begin
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      digit_ff  <= digit_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

// ===== src/stoi_ctrl.sv =====
// ---------------------------------------------------------------------------
// stoi_ctrl
// parse phase state machine, handshake control and datapath commands
// ---------------------------------------------------------------------------
module stoi_ctrl
   import stoi_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  stoi_status_type st,
   output stoi_cmd_type    cmd
);

   localparam logic [2:0] S_LEAD   = 3'd0;
   localparam logic [2:0] S_SIGNED = 3'd1;
   localparam logic [2:0] S_ZERO   = 3'd2;
   localparam logic [2:0] S_DIGITS = 3'd3;
   localparam logic [2:0] S_TRAIL  = 3'd4;
   localparam logic [2:0] S_ABSORB = 3'd5;
   localparam logic [2:0] S_MULT   = 3'd6;

   localparam logic [1:0] BSEL_HELD  = 2'd0;
   localparam logic [1:0] BSEL_RADIX = 2'd1;
   localparam logic [1:0] BSEL_TEN   = 2'd2;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // nul beats wait while a result is still held; multiply commit stalls all
   assign req_stall = (state_ff == S_MULT) | (rsp_valid_ff & rsp_stall & st.is_nul);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      logic [2:0] p;
      logic [1:0] bsel;
      logic       done;
      logic       dig_ok;
      logic       base_auto;

      cmd      = '0;
      cmd.base_op = BOP_NONE;
      state_in = state_ff;
      p        = state_ff;
      bsel     = BSEL_HELD;
      done     = 1'b0;
      dig_ok   = 1'b0;
      // automatic base: the radix register while in lead, else the held base
      base_auto = (state_ff == S_LEAD) ? st.radix_auto : st.held_auto;

      if (state_ff == S_MULT) begin
         cmd.commit = 1'b1;
         state_in   = st.overflow ? S_ABSORB : S_DIGITS;
      end else if (accept) begin
         if (state_ff == S_LEAD) begin
            cmd.base_op = BOP_RADIX;
            bsel        = BSEL_RADIX;
            if (st.base_bad) begin
               cmd.set_invalid = 1'b1;
               p               = S_ABSORB;
            end
         end

         if (st.is_nul) begin
            cmd.emit  = 1'b1;
            cmd.clear = 1'b1;
            state_in  = S_LEAD;
         end else begin
            if (p == S_LEAD) begin
               if (st.is_blank) begin
                  done = 1'b1;
               end else begin
                  p = S_SIGNED;
                  if (st.is_sign) begin
                     cmd.set_sign = 1'b1;
                     state_in     = S_SIGNED;
                     done         = 1'b1;
                  end
               end
            end

            if (!done && (p == S_SIGNED)) begin
               if (base_auto) begin
                  if (st.is_char0) begin
                     cmd.base_op = BOP_EIGHT;
                     state_in    = S_ZERO;
                     done        = 1'b1;
                  end else begin
                     cmd.base_op = BOP_TEN;
                     bsel        = BSEL_TEN;
                  end
               end
               p = S_DIGITS;
            end

            if (!done && (p == S_ZERO)) begin
               p = S_DIGITS;
               if (st.is_x) begin
                  cmd.base_op = BOP_SIXTEEN;
                  state_in    = S_DIGITS;
                  done        = 1'b1;
               end
            end

            if (!done && (p == S_DIGITS)) begin
               unique case (bsel)
                  BSEL_RADIX: dig_ok = st.digit_lt_radix;
                  BSEL_TEN:   dig_ok = st.digit_lt_ten;
                  default:    dig_ok = st.digit_lt_held;
               endcase
               priority if (dig_ok) begin
                  cmd.start_mul = 1'b1;
                  state_in      = S_MULT;
               end else if (st.is_blank) begin
                  state_in = S_TRAIL;
               end else begin
                  cmd.set_invalid = 1'b1;
                  state_in        = S_ABSORB;
               end
            end else if (!done && (p == S_TRAIL)) begin
               if (!st.is_blank) begin
                  cmd.set_invalid = 1'b1;
                  state_in        = S_ABSORB;
               end
            end else if (!done && (p == S_ABSORB)) begin
               state_in = S_ABSORB;
            end
         end
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/stoi_checker.sv =====
// ---------------------------------------------------------------------------
// stoi_checker
// port-level checks on the parser's handshakes and results
// ---------------------------------------------------------------------------
`include "string_to_signed_integer_parser_assert.svh"

module stoi_checker
   import stoi_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [CHAR_WIDTH-1:0]       req_char_code,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [OUT_WIDTH-1:0] rsp_value,
   input logic [STATUS_WIDTH-1:0]     rsp_status
);

   // a stalled result beat holds
   `STOI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value) && $stable(rsp_status))

   // an accepted terminator always yields a result beat
   `STOI_ASSERT_NEXT(a_nul_gives_rsp, clock, reset, req_valid && !req_stall && (req_char_code == NUL_CHAR), rsp_valid)

   // a new result appears only after a terminator was taken
   `STOI_ASSERT_SAME(a_rsp_from_nul, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && (req_char_code == NUL_CHAR)))

   // out of range always comes with a saturated value
   `STOI_ASSERT_SAME(a_range_saturates, clock, reset, rsp_valid && (rsp_status == STATUS_RANGE), (rsp_value == SAT_MAX_EXT) || (rsp_value == SAT_MIN_EXT))

endmodule

bind string_to_signed_integer_parser stoi_checker u_checker (.*);
